@@ design/drive_duty_dither_brake_limiter_unit_assert.svh @@
// Assertion macros for the duty shaper block.
// Used by the top level only; needs clk and rst_n in scope where expanded.
`ifndef DRIVE_DUTY_DITHER_BRAKE_LIMITER_UNIT_ASSERT_SVH
`define DRIVE_DUTY_DITHER_BRAKE_LIMITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DDBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDBL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDBL_ASSERT(label, prop, msg)
`define DDBL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ design/ddbl_pkg.sv @@
// Shared types, constants and dither pattern table for the duty shaper.
// No dependencies.
package ddbl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_SHAPE,
    ST_DIV2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int DVD_W   = 32;
  localparam int DSR_W   = 17;
  localparam int QUO_W   = 16;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int LIMIT_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT = 8'd1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 15'd16384;

  localparam logic [DSR_W-1:0]  Q_ONE      = 17'd32768;
  localparam logic [17:0]       MARGIN_Q   = 18'd1638;
  localparam logic signed [16:0] NEAR_HI   = 17'sd3;
  localparam logic signed [16:0] NEAR_LO   = -17'sd3;
  localparam logic [3:0]        LEVEL_FULL = 4'd8;
  localparam logic signed [18:0] DUTY_MAX  = 19'sd32767;
  localparam logic signed [18:0] DUTY_MIN  = -19'sd32768;

  // Brake dither pattern per level, bit n used at phase n.
  function automatic logic [7:0] dither_pattern(input logic [3:0] level);
    logic [7:0] pat;
    unique case (level)
      4'd0:    pat = 8'h00;
      4'd1:    pat = 8'h01;
      4'd2:    pat = 8'h11;
      4'd3:    pat = 8'h25;
      4'd4:    pat = 8'h55;
      4'd5:    pat = 8'hD5;
      4'd6:    pat = 8'hEE;
      4'd7:    pat = 8'hFE;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

@@ design/drive_duty_dither_brake_limiter_unit.sv @@
// Duty shaper with brake dither and current limits; top level.
// One item at a time: a beat is taken only in idle, then prep, the first
// divider pass, shaping, the second pass and emit; the shared divider runs two
// 16-step passes per item (shaping or brake level, then the reverse limit).
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, synchronous, active low): idle, output empty, phase 0, limits 0.5.
`include "drive_duty_dither_brake_limiter_unit_assert.svh"

module drive_duty_dither_brake_limiter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] duty_request, [31:16] measured_speed
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,
  // out_tdata: [15:0] duty_out, [16] brake_now, [23:17] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddbl_pkg::CFG_DAT_W-1:0]    cfg_data
);

  ddbl_pkg::state_t state_r, state_nxt;

  // item context, mirrored to non-negative speed
  logic signed [16:0] d_r, d_nxt;
  logic [15:0]        s_r, s_nxt;
  logic               neg_r, neg_nxt;
  logic               accel_r, accel_nxt;   // speeding up, request passes
  logic               pos_r, pos_nxt;       // slowing to non-negative target
  logic               full_r, full_nxt;     // full braking level
  logic signed [16:0] duty_r, duty_nxt;
  logic               brake_r, brake_nxt;
  logic [2:0]         phase_r, phase_nxt;

  logic [ddbl_pkg::LIMIT_W-1:0] fcl_r, fcl_nxt;
  logic [ddbl_pkg::LIMIT_W-1:0] rcl_r, rcl_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_duty_r, out_duty_nxt;
  logic        out_brake_r, out_brake_nxt;

  // divider hookup
  logic                          div_start;
  logic [ddbl_pkg::DVD_W-1:0]    div_dividend;
  logic [ddbl_pkg::DSR_W-1:0]    div_divisor;
  ddbl_pkg::div_stat_t           div_stat;
  logic [ddbl_pkg::QUO_W-1:0]    quotient;

  // combinational helpers
  logic               in_beat, slot_free;
  logic signed [16:0] in_d17, in_s17, d_mir, s_mir;
  logic signed [17:0] d18, s18, mag;
  logic [ddbl_pkg::DSR_W-1:0] one_plus_s;
  logic signed [16:0] shaped;
  logic [3:0]         level;
  logic [7:0]         pattern;
  logic signed [18:0] duty19, s19, cap, lim, lim_d, fin;

  ddbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_tready = (state_r == ddbl_pkg::ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    // input mirroring: -1.0 becomes +1.0, hence 17 bits
    in_d17 = {in_tdata[15], in_tdata[15:0]};
    in_s17 = {in_tdata[31], in_tdata[31:16]};
    d_mir  = in_tdata[31] ? -in_d17 : in_d17;
    s_mir  = in_tdata[31] ? -in_s17 : in_s17;

    d18 = {d_r[16], d_r};
    s18 = {2'b00, s_r};
    mag = s18 - d18;
    one_plus_s = {1'b0, s_r} + ddbl_pkg::Q_ONE;

    // shaping step, quotient from first pass
    if (accel_r) begin
      shaped = d_r;
    end else if (pos_r) begin
      shaped = '0;
    end else begin
      shaped = 17'sd0 - $signed({1'b0, quotient});
    end
    if (accel_r || !pos_r) begin
      level = '0;
    end else if (full_r) begin
      level = ddbl_pkg::LEVEL_FULL;
    end else begin
      level = {1'b0, quotient[2:0]};
    end
    pattern = ddbl_pkg::dither_pattern(level);

    // current limits, quotient from second pass
    duty19 = {{2{duty_r[16]}}, duty_r};
    s19    = {3'b000, s_r};
    cap    = s19 + {4'b0000, fcl_r};
    lim    = 19'sd0 - $signed({3'b000, quotient});
    lim_d  = duty19;
    if (duty19 > s19) begin
      if (duty19 > cap) lim_d = cap;
    end else if (duty19 < 19'sd0) begin
      if (duty19 < lim) lim_d = lim;
    end
    fin = neg_r ? -lim_d : lim_d;
  end

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    neg_nxt       = neg_r;
    accel_nxt     = accel_r;
    pos_nxt       = pos_r;
    full_nxt      = full_r;
    duty_nxt      = duty_r;
    brake_nxt     = brake_r;
    phase_nxt     = phase_r;
    out_duty_nxt  = out_duty_r;
    out_brake_nxt = out_brake_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_start     = 1'b0;
    div_dividend  = {2'b00, rcl_r, 15'd0};
    div_divisor   = one_plus_s;

    unique case (state_r)
      ddbl_pkg::ST_IDLE: begin
        if (in_beat) begin
          d_nxt     = d_mir;
          s_nxt     = s_mir[15:0];
          neg_nxt   = in_tdata[31];
          state_nxt = ddbl_pkg::ST_PREP;
        end
      end
      ddbl_pkg::ST_PREP: begin
        accel_nxt = (d18 >= s18);
        pos_nxt   = !d_r[16];
        // braking margin: level from division only when speed clears it
        full_nxt  = ({2'b00, s_r} <= (mag + ddbl_pkg::MARGIN_Q));
        div_start = 1'b1;
        if (!d_r[16]) begin
          // floor(8*mag/s); mag <= s here so 16 bits suffice
          div_dividend = {13'd0, mag[15:0], 3'b000};
          div_divisor  = {1'b0, s_r};
        end else begin
          div_dividend = {1'b0, mag[15:0], 15'd0};
        end
        state_nxt = ddbl_pkg::ST_DIV1;
      end
      ddbl_pkg::ST_DIV1: begin
        if (div_stat.done) state_nxt = ddbl_pkg::ST_SHAPE;
      end
      ddbl_pkg::ST_SHAPE: begin
        if (shaped >= ddbl_pkg::NEAR_LO && shaped <= ddbl_pkg::NEAR_HI) begin
          duty_nxt  = '0;
          phase_nxt = phase_r + 3'd1;
          brake_nxt = pattern[phase_nxt];
        end else begin
          duty_nxt  = shaped;
          brake_nxt = 1'b0;
        end
        div_start = 1'b1;   // reverse limit: rcl/(1+s)
        state_nxt = ddbl_pkg::ST_DIV2;
      end
      ddbl_pkg::ST_DIV2: begin
        if (div_stat.done) state_nxt = ddbl_pkg::ST_EMIT;
      end
      ddbl_pkg::ST_EMIT: begin
        if (slot_free) begin
          if (fin > ddbl_pkg::DUTY_MAX) begin
            out_duty_nxt = ddbl_pkg::DUTY_MAX[15:0];
          end else if (fin < ddbl_pkg::DUTY_MIN) begin
            out_duty_nxt = ddbl_pkg::DUTY_MIN[15:0];
          end else begin
            out_duty_nxt = fin[15:0];
          end
          out_brake_nxt = brake_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ddbl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ddbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fcl_nxt = fcl_r;
    rcl_nxt = rcl_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == ddbl_pkg::CFG_FWD_LIMIT) begin
        fcl_nxt = cfg_data[ddbl_pkg::LIMIT_W-1:0];
      end else if (cfg_index == ddbl_pkg::CFG_REV_LIMIT) begin
        rcl_nxt = cfg_data[ddbl_pkg::LIMIT_W-1:0];
      end else begin
        fcl_nxt = fcl_r;   // unknown index, dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddbl_pkg::ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      fcl_r       <= ddbl_pkg::LIMIT_RESET;
      rcl_r       <= ddbl_pkg::LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      fcl_r       <= fcl_nxt;
      rcl_r       <= rcl_nxt;
    end
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    neg_r       <= neg_nxt;
    accel_r     <= accel_nxt;
    pos_r       <= pos_nxt;
    full_r      <= full_nxt;
    duty_r      <= duty_nxt;
    brake_r     <= brake_nxt;
    out_duty_r  <= out_duty_nxt;
    out_brake_r <= out_brake_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_brake_r, out_duty_r};

  // divider must be quiet whenever a new beat can be taken
  `DDBL_ASSERT(a_idle_div_quiet, in_tready |-> !div_stat.busy, "divider busy while idle")
  // a pass is never restarted mid-flight
  `DDBL_ASSERT(a_no_restart, div_start |-> !div_stat.busy, "divider restarted while busy")
  // dither phase only moves in the shaping step
  `DDBL_ASSERT_ALWAYS(a_phase_hold,
    (rst_n && state_r != ddbl_pkg::ST_SHAPE) |=> $stable(phase_r), "phase moved off shaping")

endmodule

@@ design/ddbl_div.sv @@
// Shared restoring divider, one quotient bit per cycle, 16 steps.
// Depends on ddbl_pkg. Caller guarantees dividend[31:16] < divisor.
module ddbl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ddbl_pkg::DVD_W-1:0]    dividend,
  input  logic [ddbl_pkg::DSR_W-1:0]    divisor,
  output ddbl_pkg::div_stat_t           stat,
  output logic [ddbl_pkg::QUO_W-1:0]    quotient
);

  logic [ddbl_pkg::DSR_W-1:0] rem_r, rem_nxt;
  logic [ddbl_pkg::QUO_W-1:0] lo_r, lo_nxt;
  logic [ddbl_pkg::DSR_W-1:0] dsr_r, dsr_nxt;
  logic [ddbl_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [ddbl_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ddbl_pkg::DSR_W:0]   trial, diff;
  logic                       ge;

  always_comb begin
    trial = {rem_r, lo_r[ddbl_pkg::QUO_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    dsr_nxt = dsr_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = {1'b0, dividend[ddbl_pkg::DVD_W-1:ddbl_pkg::QUO_W]};
      lo_nxt  = dividend[ddbl_pkg::QUO_W-1:0];
      dsr_nxt = divisor;
      cnt_nxt = ddbl_pkg::CNT_W'(ddbl_pkg::QUO_W);
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so 17 bits hold it
      rem_nxt = ge ? diff[ddbl_pkg::DSR_W-1:0] : trial[ddbl_pkg::DSR_W-1:0];
      lo_nxt  = {lo_r[ddbl_pkg::QUO_W-2:0], 1'b0};
      q_nxt   = {q_r[ddbl_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = (cnt_r == ddbl_pkg::CNT_W'(1));
  assign quotient  = q_r;

endmodule

@@ verif/ddbl_checker.sv @@
// Scoreboard for the duty shaper: watches the input, result and register write channels.
// Predicts each result from its own copy of the limits and the dither phase.
// Depends on ddbl_pkg for the register indexes and port widths.
module ddbl_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ddbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddbl_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q15     = 32768;
  localparam longint BRAKE_GAP   = 1638;  // 0.05 margin
  localparam longint NEAR_ZERO   = 3;
  localparam int     REPORT_MAX  = 10;
  // level n occupies bits [8n+7:8n]; bit p of a pattern is used at phase p
  localparam logic [71:0] BRAKE_PATTERNS = {8'hFF, 8'hFE, 8'hEE, 8'hD5, 8'h55,
                                            8'h25, 8'h11, 8'h01, 8'h00};

  typedef struct packed {
    logic [6:0]  pad;
    logic        brake;
    logic [15:0] duty;
  } duty_beat_t;

  duty_beat_t  expected_duty_q[$];
  logic [14:0] fwd_limit;
  logic [14:0] rev_limit;
  logic [2:0]  dither_phase;
  int          mismatches;

  // Works on the mirrored (non-negative) speed; advances the phase on near-zero duty.
  function automatic duty_beat_t shape_duty(input logic signed [15:0] req,
                                            input logic signed [15:0] spd);
    longint     d;
    longint     s;
    longint     mag;
    longint     lvl;
    longint     duty;
    longint     cap;
    longint     floor_lim;
    bit         mirrored;
    duty_beat_t res;
    d = req;
    s = spd;
    mirrored = (s < 0);
    res = '0;
    lvl = 0;
    if (mirrored) begin
      d = -d;
      s = -s;
    end
    if (d >= s) begin
      duty = d;
    end else begin
      mag = s - d;
      if (d >= 0) begin
        lvl = (s > mag + BRAKE_GAP) ? (mag * 8) / s : 8;
        duty = 0;
      end else begin
        duty = -((mag * ONE_Q15) / (ONE_Q15 + s));
      end
    end
    if (duty >= -NEAR_ZERO && duty <= NEAR_ZERO) begin
      duty = 0;
      dither_phase = dither_phase + 3'd1;
      if (lvl > 8) lvl = 8;
      res.brake = BRAKE_PATTERNS[lvl * 8 + dither_phase];
    end
    if (duty > s) begin
      cap = s + fwd_limit;
      if (duty > cap) duty = cap;
    end else if (duty < 0) begin
      floor_lim = -((rev_limit * ONE_Q15) / (ONE_Q15 + s));
      if (duty < floor_lim) duty = floor_lim;
    end
    if (mirrored) duty = -duty;
    if (duty > 32767) duty = 32767;
    if (duty < -32768) duty = -32768;
    res.duty = duty[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    duty_beat_t want;
    duty_beat_t got;
    if (!rst_n) begin
      expected_duty_q.delete();
      fwd_limit    = ddbl_pkg::LIMIT_RESET;
      rev_limit    = ddbl_pkg::LIMIT_RESET;
      dither_phase = 3'd0;
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ddbl_pkg::CFG_FWD_LIMIT) fwd_limit = cfg_data[14:0];
        else if (cfg_index == ddbl_pkg::CFG_REV_LIMIT) rev_limit = cfg_data[14:0];
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_duty_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result beat duty=%0d brake=%0b", $realtime,
                     $signed(got.duty), got.brake);
        end else begin
          want = expected_duty_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"%0t: result mismatch: duty exp %0d got %0d, ",
                        "brake exp %0b got %0b, pad exp %h got %h"},
                       $realtime, $signed(want.duty), $signed(got.duty),
                       want.brake, got.brake, want.pad, got.pad);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_duty_q.push_back(shape_duty(in_tdata[15:0], in_tdata[31:16]));
    end
    fail_count    <= mismatches;
    pending_beats <= expected_duty_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Top of the duty shaper testbench: clock, reset, stimulus, back-pressure and verdict.
// Instantiates drive_duty_dither_brake_limiter_unit and ddbl_checker; uses ddbl_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_CYCLES = 40;      // the block's latency to out_tvalid, rounded up
  localparam int CYCLE_LIMIT    = 400000;  // several times the slowest correct run
  localparam int BLOCK_ITEMS    = 100;
  // indexes with no register behind them; writes must be dropped
  localparam logic [ddbl_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
  localparam logic [ddbl_pkg::CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;   // [15:0] duty_request, [31:16] measured_speed
  logic                           out_tvalid;
  logic                           out_tready;
  logic [23:0]                    out_tdata;  // [15:0] duty_out, [16] brake_now, [23:17] zero
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ddbl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ddbl_pkg::CFG_DAT_W-1:0] cfg_data;

  int fail_count;
  int pending_beats;
  int cycle_count = 0;
  bit quiet = 1'b0;  // set for the closing block: no gaps, no stalls

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  drive_duty_dither_brake_limiter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ddbl_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts, none once quiet.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // One input beat; valid stays high into the next call unless a gap is drawn,
  // so valid is never dropped and raised in the same step.
  task automatic push_beat(input int duty, input int speed);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {speed[15:0], duty[15:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain: every predicted result back, then the block's latency on top.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddbl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddbl_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes, near-zero codes and full-range noise.
  function automatic logic [15:0] pick_q15();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return r[2:0] - 16'd4;
      default: return r[15:0];
    endcase
  endfunction

  // Mostly deceleration near the brake margin and small duties, where the
  // dither and divider paths live, plus acceleration past the speed; the rest is unrestricted.
  task automatic run_random(input int count);
    logic [15:0] speed;
    logic [15:0] duty;
    logic [15:0] offset;
    for (int i = 0; i < count; i++) begin
      speed  = pick_q15();
      offset = 16'($urandom_range(0, 4095));
      case ($urandom_range(0, 4))
        0:       duty = speed - offset;
        1:       duty = speed + offset;
        2:       duty = offset - 16'd2048;
        3:       duty = speed - {offset[12:0], 3'd0};
        default: duty = pick_q15();
      endcase
      push_beat(int'(duty), int'(speed));
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset limits of one half.
    push_beat(0, 0);                // still, no brake level
    push_beat(3, 0);                // near-zero duty forced to zero
    push_beat(-3, 0);
    push_beat(4, 0);                // just outside the near-zero band
    push_beat(32767, 0);            // forward limit bites
    push_beat(-32768, 0);           // reverse limit bites
    push_beat(32767, 32767);
    push_beat(-32768, -32768);      // mirrored -1.0 becomes +1.0
    push_beat(32767, -32768);
    push_beat(-32768, 32767);
    push_beat(1638, 20000);         // on the margin: full braking
    push_beat(1639, 20000);         // just past it: level 7
    push_beat(19999, 20000);        // level 0
    push_beat(-1638, -20000);       // on the margin again, negative speed
    push_beat(-10000, 5000);        // reverse with power
    push_beat(10000, -5000);
    push_beat(0, -32768);
    for (int i = 0; i < 8; i++)
      push_beat(10000, 20000);      // one full turn of the dither phase at level 4
    settle();

    // Both limits closed.
    write_reg(ddbl_pkg::CFG_FWD_LIMIT, 16'h0000);
    write_reg(ddbl_pkg::CFG_REV_LIMIT, 16'h0000);
    push_beat(32767, 0);
    push_beat(-20000, 1000);
    run_random(BLOCK_ITEMS);
    settle();

    // Both limits fully open; top bit of the write must be dropped.
    write_reg(ddbl_pkg::CFG_FWD_LIMIT, 16'hFFFF);
    write_reg(ddbl_pkg::CFG_REV_LIMIT, 16'hFFFF);
    push_beat(-32768, -1);          // +1.0 inside the block, leaves as -1.0
    push_beat(32767, 0);
    push_beat(-32767, 1);
    run_random(BLOCK_ITEMS);
    settle();

    // Odd limit values around writes to indexes with no register.
    write_reg(ddbl_pkg::CFG_FWD_LIMIT, 16'h8001);
    write_reg(CFG_SPARE_IDX, 16'h1234);
    write_reg(CFG_TOP_IDX, 16'h0000);
    write_reg(ddbl_pkg::CFG_REV_LIMIT, 16'($urandom));
    run_random(BLOCK_ITEMS);
    settle();

    write_reg(ddbl_pkg::CFG_FWD_LIMIT, 16'($urandom));
    write_reg(ddbl_pkg::CFG_REV_LIMIT, 16'($urandom));
    run_random(BLOCK_ITEMS);
    settle();

    // Closing block at full rate, back to the reset limits.
    quiet = 1'b1;
    write_reg(ddbl_pkg::CFG_FWD_LIMIT, {1'b0, ddbl_pkg::LIMIT_RESET});
    write_reg(ddbl_pkg::CFG_REV_LIMIT, {1'b0, ddbl_pkg::LIMIT_RESET});
    run_random(BLOCK_ITEMS);
    settle();

    if (fail_count == 0 && pending_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ddbl_pkg.sv
design/ddbl_div.sv
design/drive_duty_dither_brake_limiter_unit.sv
verif/ddbl_checker.sv
verif/tb_top.sv
